// ----- sv/mips_instruction_execute_core_defines.svh -----
// Assertion macros shared by the execute core RTL.
// No dependencies; included by files that carry assertions.
`ifndef MIPS_INSTRUCTION_EXECUTE_CORE_DEFINES_SVH
`define MIPS_INSTRUCTION_EXECUTE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- sv/mie_pkg.sv -----
// Shared types and encodings for the MIPS32 execute core.
// No dependencies.
`timescale 1ns / 1ps
package mie_pkg;
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0a;
  localparam logic [5:0] OP_SLTIU = 6'h0b;
  localparam logic [5:0] OP_ANDI  = 6'h0c;
  localparam logic [5:0] OP_ORI   = 6'h0d;
  localparam logic [5:0] OP_XORI  = 6'h0e;
  localparam logic [5:0] OP_LUI   = 6'h0f;
  localparam logic [5:0] OP_LB    = 6'h20;
  localparam logic [5:0] OP_LH    = 6'h21;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_LBU   = 6'h24;
  localparam logic [5:0] OP_LHU   = 6'h25;
  localparam logic [5:0] OP_SB    = 6'h28;
  localparam logic [5:0] OP_SH    = 6'h29;
  localparam logic [5:0] OP_SW    = 6'h2b;

  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0c;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2a;
  localparam logic [5:0] FN_SLTU    = 6'h2b;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SYSCALL = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;
  localparam logic [1:0] ST_BADMEM  = 2'd3;

  localparam logic [4:0] LINK_REG = 5'd31;
  localparam logic [31:0] PC_REGION = 32'hf000_0000;

  typedef enum logic [1:0] {SZ_NONE, SZ_BYTE, SZ_HALF, SZ_WORD} msize_t;

  typedef struct packed {
    logic        wr;
    logic [4:0]  widx;
    logic [31:0] wval;
    logic [31:0] npc;
    logic [1:0]  status;
    logic        hilo_we;
    logic [31:0] hi;
    logic [31:0] lo;
    logic        ld;
    logic        st;
    logic        ld_sx;
    msize_t      msize;
    logic [31:0] addr;
  } exec_t;
endpackage

// ----- sv/mie_exec.sv -----
// Combinational execute: decode, ALU, multiply, branch and address checks.
// Depends on mie_pkg.
`timescale 1ns / 1ps
module mie_exec import mie_pkg::*; #(
  parameter int MEM_BYTES = 65536
) (
  input  logic [31:0] instr,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] pc,
  input  logic [31:0] hi,
  input  logic [31:0] lo,
  output exec_t       ex
);
  localparam logic [32:0] MEM_LIM = 33'(MEM_BYTES);

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [31:0] imm;
  logic [31:0] simm;
  logic [31:0] pc4;
  logic [31:0] addr;
  logic        mult_sx;
  logic signed [65:0] prod;
  logic [32:0] mend;
  logic        aok;
  exec_t       e;

  assign op   = instr[31:26];
  assign fn   = instr[5:0];
  assign rt   = instr[20:16];
  assign rd   = instr[15:11];
  assign sh   = instr[10:6];
  assign imm  = {16'h0, instr[15:0]};
  assign simm = {{16{instr[15]}}, instr[15:0]};
  assign pc4  = pc + 32'd4;
  assign addr = a + simm;
  assign mult_sx = (fn == FN_MULT);
  assign prod = $signed({mult_sx & a[31], a}) * $signed({mult_sx & b[31], b});

  always_comb begin
    e = '0;
    e.npc = pc4;
    e.status = ST_OK;
    e.msize = SZ_NONE;
    e.addr = addr;
    e.hi = prod[63:32];
    e.lo = prod[31:0];
    case (op)
      OP_SPECIAL: begin
        case (fn)
          FN_SLL: begin e.wr = 1'b1; e.widx = rd; e.wval = b << sh; end
          FN_SRL: begin e.wr = 1'b1; e.widx = rd; e.wval = b >> sh; end
          FN_SRA: begin e.wr = 1'b1; e.widx = rd; e.wval = 32'($signed(b) >>> sh); end
          FN_JR: e.npc = a;
          FN_JALR: begin e.wr = 1'b1; e.widx = rd; e.wval = pc4; e.npc = a; end
          FN_SYSCALL: e.status = ST_SYSCALL;
          FN_MFHI: begin e.wr = 1'b1; e.widx = rd; e.wval = hi; end
          FN_MFLO: begin e.wr = 1'b1; e.widx = rd; e.wval = lo; end
          FN_MULT, FN_MULTU: e.hilo_we = 1'b1;
          FN_ADDU: begin e.wr = 1'b1; e.widx = rd; e.wval = a + b; end
          FN_SUBU: begin e.wr = 1'b1; e.widx = rd; e.wval = a - b; end
          FN_AND: begin e.wr = 1'b1; e.widx = rd; e.wval = a & b; end
          FN_OR: begin e.wr = 1'b1; e.widx = rd; e.wval = a | b; end
          FN_XOR: begin e.wr = 1'b1; e.widx = rd; e.wval = a ^ b; end
          FN_NOR: begin e.wr = 1'b1; e.widx = rd; e.wval = ~(a | b); end
          FN_SLT: begin
            e.wr = 1'b1; e.widx = rd; e.wval = {31'h0, $signed(a) < $signed(b)};
          end
          FN_SLTU: begin e.wr = 1'b1; e.widx = rd; e.wval = {31'h0, a < b}; end
          default: e.status = ST_ILLEGAL;
        endcase
      end
      OP_J: e.npc = (pc4 & PC_REGION) | {4'h0, instr[25:0], 2'b00};
      OP_JAL: begin
        e.wr = 1'b1; e.widx = LINK_REG; e.wval = pc4;
        e.npc = (pc4 & PC_REGION) | {4'h0, instr[25:0], 2'b00};
      end
      OP_BEQ: if (a == b) e.npc = pc4 + {simm[29:0], 2'b00};
      OP_BNE: if (a != b) e.npc = pc4 + {simm[29:0], 2'b00};
      OP_ADDIU: begin e.wr = 1'b1; e.widx = rt; e.wval = a + simm; end
      OP_SLTI: begin
        e.wr = 1'b1; e.widx = rt; e.wval = {31'h0, $signed(a) < $signed(simm)};
      end
      OP_SLTIU: begin e.wr = 1'b1; e.widx = rt; e.wval = {31'h0, a < simm}; end
      OP_ANDI: begin e.wr = 1'b1; e.widx = rt; e.wval = a & imm; end
      OP_ORI: begin e.wr = 1'b1; e.widx = rt; e.wval = a | imm; end
      OP_XORI: begin e.wr = 1'b1; e.widx = rt; e.wval = a ^ imm; end
      OP_LUI: begin e.wr = 1'b1; e.widx = rt; e.wval = {instr[15:0], 16'h0}; end
      OP_LB: begin e.ld = 1'b1; e.ld_sx = 1'b1; e.msize = SZ_BYTE; end
      OP_LBU: begin e.ld = 1'b1; e.msize = SZ_BYTE; end
      OP_LH: begin e.ld = 1'b1; e.ld_sx = 1'b1; e.msize = SZ_HALF; end
      OP_LHU: begin e.ld = 1'b1; e.msize = SZ_HALF; end
      OP_LW: begin e.ld = 1'b1; e.msize = SZ_WORD; end
      OP_SB: begin e.st = 1'b1; e.msize = SZ_BYTE; end
      OP_SH: begin e.st = 1'b1; e.msize = SZ_HALF; end
      OP_SW: begin e.st = 1'b1; e.msize = SZ_WORD; end
      default: e.status = ST_ILLEGAL;
    endcase
  end

  always_comb begin
    case (e.msize)
      SZ_BYTE: mend = {1'b0, addr} + 33'd1;
      SZ_HALF: mend = {1'b0, addr} + 33'd2;
      default: mend = {1'b0, addr} + 33'd4;
    endcase
    case (e.msize)
      SZ_HALF: aok = !addr[0];
      SZ_WORD: aok = (addr[1:0] == 2'b00);
      default: aok = 1'b1;
    endcase
    aok = aok && (addr != 32'h0) && (mend <= MEM_LIM);
  end

  always_comb begin
    ex = e;
    if ((e.ld || e.st) && !aok) begin
      ex.status = ST_BADMEM;
      ex.ld = 1'b0;
      ex.st = 1'b0;
    end
    if (ex.status == ST_ILLEGAL || ex.status == ST_BADMEM) begin
      ex.wr = 1'b0;
      ex.npc = pc;
    end
    if (ex.widx == 5'd0) ex.wr = 1'b0;
    if (!ex.wr) begin
      ex.widx = 5'd0;
      ex.wval = 32'h0;
    end
  end
endmodule

// ----- sv/mie_dmem.sv -----
// Byte-lane data memory, one word per row, registered read, clear sweep after reset.
// Depends on mie_pkg.
`timescale 1ns / 1ps
module mie_dmem import mie_pkg::*; #(
  parameter int MEM_BYTES = 65536
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             we,
  input  logic [3:0]                       be,
  input  logic [$clog2(MEM_BYTES/4)-1:0]   waddr,
  input  logic [31:0]                      wdata,
  input  logic                             re,
  input  logic [$clog2(MEM_BYTES/4)-1:0]   raddr,
  output logic [31:0]                      rdata,
  output logic                             busy
);
  localparam int WORDS = MEM_BYTES / 4;
  localparam int WAW = $clog2(WORDS);

  logic [31:0]    mem [WORDS];
  logic [WAW-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == WAW'(WORDS - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_cnt] <= 32'h0;
    end else if (we) begin
      for (int i = 0; i < 4; i++) begin
        if (be[i]) mem[waddr][8*i +: 8] <= wdata[8*i +: 8];
      end
    end
    if (re) rdata <= mem[raddr];
  end
endmodule

// ----- sv/mips_instruction_execute_core.sv -----
// Top level of the MIPS32 execute core: input register, execute, result register.
// Depends on mie_pkg, mie_exec, mie_dmem and the assertion macro header.
//
// Channel   Dir  Beat contents
// s_axis    in   tdata[31:0] instr_word
// m_axis    out  tdata: next_pc, status, reg_written, reg_index, reg_value
//
// One instruction per cycle while m_axis accepts results and no load is pending; a load waits for
// the registered memory read, holding the next instruction in the input register meanwhile.
// After reset a clear sweep zeroes all MEM_BYTES/4 memory words; s_axis_tready stays low meanwhile.
// A stalled m_axis holds the result register and blocks execute.
// MEM_BYTES must be a power of two.
`timescale 1ns / 1ps
`include "mips_instruction_execute_core_defines.svh"
module mips_instruction_execute_core import mie_pkg::*; #(
  parameter int MEM_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] instr_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] next_pc, [33:32] status, [34] reg_written, [39:35] reg_index,
  // [71:40] reg_value
  output logic [71:0] m_axis_tdata
);
  localparam int WAW = $clog2(MEM_BYTES / 4);

  logic [31:0] gp [32];
  logic [31:0] pc;
  logic [31:0] hi;
  logic [31:0] lo;
  logic        in_v;
  logic [31:0] in_word;
  logic        out_v;
  logic [31:0] o_npc;
  logic [1:0]  o_status;
  logic        o_wr;
  logic [4:0]  o_widx;
  logic [31:0] o_wval;
  logic        ld_pend;
  logic [4:0]  ld_idx;
  logic        ld_sx;
  msize_t      ld_size;
  logic [1:0]  ld_off;
  logic [31:0] ld_npc;

  exec_t       ex;
  logic        mem_busy;
  logic [31:0] rdata;
  logic        in_adv;
  logic        ld_done;
  logic [3:0]  be;
  logic [31:0] wdata;
  logic [31:0] ld_shift;
  logic [31:0] ld_val;

  mie_exec #(.MEM_BYTES(MEM_BYTES)) u_exec (
    .instr (in_word),
    .a     (gp[in_word[25:21]]),
    .b     (gp[in_word[20:16]]),
    .pc    (pc),
    .hi    (hi),
    .lo    (lo),
    .ex    (ex)
  );

  always_comb begin
    case (ex.msize)
      SZ_BYTE: begin be = 4'b0001 << ex.addr[1:0]; wdata = {4{gp[in_word[20:16]][7:0]}}; end
      SZ_HALF: begin
        be = ex.addr[1] ? 4'b1100 : 4'b0011; wdata = {2{gp[in_word[20:16]][15:0]}};
      end
      default: begin be = 4'b1111; wdata = gp[in_word[20:16]]; end
    endcase
  end

  mie_dmem #(.MEM_BYTES(MEM_BYTES)) u_dmem (
    .clk   (clk),
    .rst   (rst),
    .we    (in_adv && ex.st),
    .be    (be),
    .waddr (ex.addr[WAW+1:2]),
    .wdata (wdata),
    .re    (in_adv && ex.ld),
    .raddr (ex.addr[WAW+1:2]),
    .rdata (rdata),
    .busy  (mem_busy)
  );

  assign in_adv  = in_v && !ld_pend && !mem_busy && (!out_v || m_axis_tready);
  assign ld_done = ld_pend && (!out_v || m_axis_tready);
  assign s_axis_tready = !mem_busy && (!in_v || in_adv);
  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = {o_wval, o_widx, o_wr, o_status, o_npc};

  always_comb begin
    ld_shift = rdata >> {ld_off, 3'b000};
    case (ld_size)
      SZ_BYTE: ld_val = {{24{ld_sx & ld_shift[7]}}, ld_shift[7:0]};
      SZ_HALF: ld_val = {{16{ld_sx & ld_shift[15]}}, ld_shift[15:0]};
      default: ld_val = ld_shift;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 32; i++) gp[i] <= 32'h0;
      pc <= 32'h0;
      hi <= 32'h0;
      lo <= 32'h0;
      in_v <= 1'b0;
      out_v <= 1'b0;
      ld_pend <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_v <= 1'b1;
        in_word <= s_axis_tdata;
      end else if (in_adv) begin
        in_v <= 1'b0;
      end
      if (m_axis_tvalid && m_axis_tready) out_v <= 1'b0;
      if (in_adv && ex.ld) begin
        ld_pend <= 1'b1;
        ld_idx <= in_word[20:16];
        ld_sx <= ex.ld_sx;
        ld_size <= ex.msize;
        ld_off <= ex.addr[1:0];
        ld_npc <= ex.npc;
      end else if (in_adv) begin
        out_v <= 1'b1;
        o_npc <= ex.npc;
        o_status <= ex.status;
        o_wr <= ex.wr;
        o_widx <= ex.widx;
        o_wval <= ex.wval;
        pc <= ex.npc;
        if (ex.wr) gp[ex.widx] <= ex.wval;
        if (ex.hilo_we) begin
          hi <= ex.hi;
          lo <= ex.lo;
        end
      end
      if (ld_done) begin
        ld_pend <= 1'b0;
        out_v <= 1'b1;
        o_npc <= ld_npc;
        o_status <= ST_OK;
        o_wr <= (ld_idx != 5'd0);
        o_widx <= ld_idx;
        o_wval <= (ld_idx != 5'd0) ? ld_val : 32'h0;
        pc <= ld_npc;
        if (ld_idx != 5'd0) gp[ld_idx] <= ld_val;
      end
    end
  end

  `ASSERT_IMPL(a_no_take_clear, clk, rst, mem_busy, !s_axis_tready, "beat taken during clear")
  `ASSERT_IMPL(a_no_exec_ld, clk, rst, ld_pend, !in_adv, "execute during pending load")
  `ASSERT_ALWAYS(a_r0_zero, clk, rst, gp[0] == 32'h0, "register zero written")
  `ASSERT_IMPL(a_wr_idx, clk, rst, out_v && o_wr, o_widx != 5'd0, "write reported to r0")
endmodule
